FILE: sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NAP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define NAP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/nap_pkg.sv
// Package: constants, command and status types, saturation helper
`timescale 1ns / 1ps
package nap_pkg;

  localparam logic [19:0] GAIN_CAP    = 20'd655360;
  localparam logic [31:0] DT_FALLBACK = 32'd4294967;
  localparam logic [6:0]  DIV_ITERS_X3   = 7'd65;
  localparam logic [6:0]  DIV_ITERS_NORM = 7'd36;

  localparam logic [2:0] REG_LEARN_RULE  = 3'd0;
  localparam logic [2:0] REG_RATE_PROP   = 3'd1;
  localparam logic [2:0] REG_RATE_INTEG  = 3'd2;
  localparam logic [2:0] REG_RATE_DERIV  = 3'd3;
  localparam logic [2:0] REG_DRIVE_MIN   = 3'd4;
  localparam logic [2:0] REG_DRIVE_MAX   = 3'd5;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd6;
  localparam logic [2:0] REG_STEP_TIME   = 3'd7;

  localparam logic [1:0] RULE_HEBB     = 2'd0;
  localparam logic [1:0] RULE_DELTA    = 2'd1;
  localparam logic [1:0] RULE_IMPROVED = 2'd2;

  localparam logic [1:0]         RST_LEARN_RULE  = RULE_IMPROVED;
  localparam logic [16:0]        RST_RATE_PROP   = 17'd13107;
  localparam logic [16:0]        RST_RATE_INTEG  = 17'd6554;
  localparam logic [16:0]        RST_RATE_DERIV  = 17'd3277;
  localparam logic signed [31:0] RST_DRIVE_MIN   = -32'sd65536000;
  localparam logic [30:0]        RST_DRIVE_MAX   = 31'd65536000;
  localparam logic [30:0]        RST_INTEG_LIMIT = 31'd32768000;
  localparam logic [31:0]        RST_STEP_TIME   = 32'd4294967;
  localparam logic [19:0]        RST_GAIN_PROP   = 20'd32768;
  localparam logic [19:0]        RST_GAIN_INTEG  = 20'd6554;
  localparam logic [19:0]        RST_GAIN_DERIV  = 20'd3277;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL_INT, OP_INTEG, OP_DIV_X3, OP_MUL_W, OP_ACC_W,
    OP_DRIVE, OP_MUL_R, OP_MUL_X, OP_GAIN, OP_SUM, OP_DIV_N, OP_NORM, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sum_zero;
    logic out_free;
  } sts_t;

  localparam logic signed [51:0] W_MAX = 52'sd2147483647;
  localparam logic signed [51:0] W_MIN = -52'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > W_MAX) r = 32'sh7FFFFFFF;
    else if (v < W_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: sv/nap_if.sv
// Channel interfaces: input, result and configuration words
`timescale 1ns / 1ps
interface nap_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] setpoint;
  logic signed [31:0] measured;
  modport source (output valid, setpoint, measured, input ready);
  modport sink (input valid, setpoint, measured, output ready);
endinterface

interface nap_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic [19:0]        gain_prop;
  logic [19:0]        gain_integ;
  logic [19:0]        gain_deriv;
  modport source (output valid, drive, gain_prop, gain_integ, gain_deriv, input ready);
  modport sink (input valid, drive, gain_prop, gain_integ, gain_deriv, output ready);
endinterface

interface nap_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/nap_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module nap_div import nap_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [64:0] dividend,
  input  logic [31:0] divisor,
  input  logic [6:0]  iters,
  output logic        done,
  output logic [64:0] quotient
);

  logic [64:0] dvd_r, dvd_nxt, q_r, q_nxt;
  logic [31:0] den_r, rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sh;

  always_comb begin
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    sh       = {rem_r, dvd_r[64]};
    if (start) begin
      dvd_nxt = dividend;
      q_nxt   = '0;
      rem_nxt = '0;
      cnt_nxt = iters;
    end else if (cnt_r != 7'd0) begin
      dvd_nxt = {dvd_r[63:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = 32'(sh - {1'b0, den_r});
        q_nxt   = {q_r[63:0], 1'b1};
      end else begin
        rem_nxt = sh[31:0];
        q_nxt   = {q_r[63:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 7'd1;
      done_nxt = (cnt_r == 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: sv/nap_dp.sv
// Datapath: registers, shared multiplier, divider and update logic
`timescale 1ns / 1ps
module nap_dp import nap_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic signed [31:0] setpoint,
  input  logic signed [31:0] measured,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_drive,
  output logic [19:0]        out_gain_prop,
  output logic [19:0]        out_gain_integ,
  output logic [19:0]        out_gain_deriv
);

  logic [1:0]         learn_r;
  logic [16:0]        rate_r [3];
  logic signed [31:0] dmin_r;
  logic [30:0]        dmax_r, ilim_r;
  logic [31:0]        step_r;

  logic signed [31:0] err_r, prior_r, integ_r, x3_r, u_r, drive_r;
  logic signed [34:0] uacc_r;
  logic [19:0]        raw_r [3];
  logic [19:0]        norm_r [3];
  logic signed [65:0] p_r;
  logic [20:0]        sum_r;
  logic               neg_r;

  logic               ov_r;
  logic signed [31:0] od_r;
  logic [19:0]        og_r [3];

  logic [31:0]        dt;
  logic signed [31:0] x_sel, s_sel;
  logic signed [32:0] ma, mb, dnum;
  logic [32:0]        dmag;
  logic signed [31:0] isat, ilim, inew, usat, dnew, dmax32;
  logic signed [50:0] dw, dwf, gcap;
  logic signed [22:0] rs;
  logic [19:0]        rnew;
  logic               same;
  logic               div_start, div_done;
  logic [64:0]        div_dvd, quot;
  logic [31:0]        div_den;
  logic [6:0]         div_iters;
  logic signed [31:0] x3_new;

  assign dt    = (step_r == 32'd0) ? DT_FALLBACK : step_r;
  assign x_sel = (cmd.idx == 2'd0) ? err_r : (cmd.idx == 2'd1) ? integ_r : x3_r;
  assign s_sel = (learn_r == RULE_HEBB) ? u_r : err_r;

  always_comb begin
    case (cmd.op)
      OP_MUL_INT: begin
        ma = 33'(err_r);
        mb = $signed({1'b0, dt});
      end
      OP_MUL_W: begin
        ma = $signed({13'd0, norm_r[cmd.idx]});
        mb = 33'(x_sel);
      end
      OP_MUL_R: begin
        ma = $signed({16'd0, rate_r[cmd.idx]});
        mb = 33'(s_sel);
      end
      OP_MUL_X: begin
        ma = p_r[48:16];
        mb = 33'(x_sel);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign dnum = 33'(err_r) - 33'(prior_r);
  assign dmag = dnum[32] ? 33'(-dnum) : 33'(dnum);

  always_comb begin
    if (cmd.op == OP_INTEG) begin
      div_dvd   = {dmag, 32'd0};
      div_den   = dt;
      div_iters = DIV_ITERS_X3;
    end else begin
      div_dvd   = {raw_r[cmd.idx], 45'd0};
      div_den   = {11'd0, sum_r};
      div_iters = DIV_ITERS_NORM;
    end
  end
  assign div_start = (cmd.op == OP_INTEG) || (cmd.op == OP_DIV_N);

  nap_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_den),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    if (neg_r) x3_new = (|quot[64:31]) ? 32'sh80000000 : -$signed(quot[31:0]);
    else       x3_new = (|quot[64:31]) ? 32'sh7FFFFFFF : $signed(quot[31:0]);
  end

  assign isat = sat32(52'(integ_r) + 52'($signed(p_r[63:32])));
  assign ilim = $signed({1'b0, ilim_r});
  always_comb begin
    inew = isat;
    if (inew > ilim) inew = ilim;
    if (inew < -ilim) inew = -ilim;
  end

  assign usat   = sat32(52'(uacc_r));
  assign dmax32 = $signed({1'b0, dmax_r});
  always_comb begin
    dnew = usat;
    if (dnew < dmin_r) dnew = dmin_r;
    if (dnew > dmax32) dnew = dmax32;
  end

  assign gcap = $signed(51'(GAIN_CAP));
  assign dw   = 51'($signed(p_r[64:16]));
  assign same = (u_r > 0 && err_r > 0) || (u_r < 0 && err_r < 0);
  always_comb begin
    case (learn_r)
      RULE_HEBB, RULE_DELTA: dwf = dw;
      RULE_IMPROVED:         dwf = same ? ((dw + (dw <<< 1)) >>> 1) : (dw >>> 1);
      default:               dwf = '0;
    endcase
    rs   = $signed({3'd0, raw_r[cmd.idx]}) + dwf[22:0];
    rnew = rs[19:0];
    if (dwf >= gcap) rnew = GAIN_CAP;
    else if (dwf <= -gcap) rnew = '0;
    else if (rs < 0) rnew = '0;
    else if (rs > 23'(GAIN_CAP)) rnew = GAIN_CAP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_r   <= RST_LEARN_RULE;
      rate_r[0] <= RST_RATE_PROP;
      rate_r[1] <= RST_RATE_INTEG;
      rate_r[2] <= RST_RATE_DERIV;
      dmin_r    <= RST_DRIVE_MIN;
      dmax_r    <= RST_DRIVE_MAX;
      ilim_r    <= RST_INTEG_LIMIT;
      step_r    <= RST_STEP_TIME;
      integ_r   <= '0;
      prior_r   <= '0;
      raw_r[0]  <= RST_GAIN_PROP;
      raw_r[1]  <= RST_GAIN_INTEG;
      raw_r[2]  <= RST_GAIN_DERIV;
      norm_r[0] <= RST_GAIN_PROP;
      norm_r[1] <= RST_GAIN_INTEG;
      norm_r[2] <= RST_GAIN_DERIV;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARN_RULE:  learn_r   <= cfg_data[1:0];
          REG_RATE_PROP:   rate_r[0] <= cfg_data[16:0];
          REG_RATE_INTEG:  rate_r[1] <= cfg_data[16:0];
          REG_RATE_DERIV:  rate_r[2] <= cfg_data[16:0];
          REG_DRIVE_MIN:   dmin_r    <= $signed(cfg_data);
          REG_DRIVE_MAX:   dmax_r    <= cfg_data[30:0];
          REG_INTEG_LIMIT: ilim_r    <= cfg_data[30:0];
          REG_STEP_TIME:   step_r    <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_INTEG: integ_r <= inew;
        OP_GAIN:  raw_r[cmd.idx] <= rnew;
        OP_NORM:  if (div_done) norm_r[cmd.idx] <= quot[19:0];
        OP_OUT:   prior_r <= err_r;
        default: ;
      endcase
      if (cmd.op == OP_OUT) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    case (cmd.op)
      OP_LOAD: begin
        err_r  <= sat32(52'(33'(setpoint) - 33'(measured)));
        uacc_r <= '0;
      end
      OP_MUL_INT, OP_MUL_W, OP_MUL_R, OP_MUL_X: p_r <= ma * mb;
      OP_INTEG:  neg_r <= dnum[32];
      OP_DIV_X3: if (div_done) x3_r <= x3_new;
      OP_ACC_W:  uacc_r <= uacc_r + 35'(sat32(52'($signed(p_r[65:16]))));
      OP_DRIVE: begin
        u_r     <= usat;
        drive_r <= dnew;
      end
      OP_SUM:    sum_r <= 21'(raw_r[0]) + 21'(raw_r[1]) + 21'(raw_r[2]);
      OP_OUT: begin
        od_r    <= drive_r;
        og_r[0] <= norm_r[0];
        og_r[1] <= norm_r[1];
        og_r[2] <= norm_r[2];
      end
      default: ;
    endcase
  end

  assign sts.div_done = div_done;
  assign sts.sum_zero = ((raw_r[0] | raw_r[1] | raw_r[2]) == 20'd0);
  assign sts.out_free = !ov_r || out_ready;

  assign out_valid      = ov_r;
  assign out_drive      = od_r;
  assign out_gain_prop  = og_r[0];
  assign out_gain_integ = og_r[1];
  assign out_gain_deriv = og_r[2];

endmodule

FILE: sv/nap_ctrl.sv
// Controller: sequences one sample through the datapath
`timescale 1ns / 1ps
module nap_ctrl import nap_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_MI   = 14'b00000000000010,
    S_INT  = 14'b00000000000100,
    S_DIVW = 14'b00000000001000,
    S_MW   = 14'b00000000010000,
    S_AW   = 14'b00000000100000,
    S_U    = 14'b00000001000000,
    S_MR   = 14'b00000010000000,
    S_MX   = 14'b00000100000000,
    S_GW   = 14'b00001000000000,
    S_SUM  = 14'b00010000000000,
    S_NDIV = 14'b00100000000000,
    S_NW   = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  op_t        op;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_MI;
        end
      end
      S_MI: begin
        op        = OP_MUL_INT;
        state_nxt = S_INT;
      end
      S_INT: begin
        op        = OP_INTEG;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        op = OP_DIV_X3;
        if (sts.div_done) begin
          idx_nxt   = 2'd0;
          state_nxt = S_MW;
        end
      end
      S_MW: begin
        op        = OP_MUL_W;
        state_nxt = S_AW;
      end
      S_AW: begin
        op = OP_ACC_W;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = S_U;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_MW;
        end
      end
      S_U: begin
        op        = OP_DRIVE;
        state_nxt = S_MR;
      end
      S_MR: begin
        op        = OP_MUL_R;
        state_nxt = S_MX;
      end
      S_MX: begin
        op        = OP_MUL_X;
        state_nxt = S_GW;
      end
      S_GW: begin
        op = OP_GAIN;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = S_SUM;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_MR;
        end
      end
      S_SUM: begin
        op        = OP_SUM;
        state_nxt = sts.sum_zero ? S_DONE : S_NDIV;
      end
      S_NDIV: begin
        op        = OP_DIV_N;
        state_nxt = S_NW;
      end
      S_NW: begin
        op = OP_NORM;
        if (sts.div_done) begin
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_NDIV;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign cmd.op  = op;
  assign cmd.idx = idx_r;

endmodule

FILE: sv/neuron_adaptive_pid_core.sv
// Top level: single-neuron adaptive PID controller core
`timescale 1ns / 1ps
// Takes one setpoint/measured word at a time and returns one word with the
// clamped drive and the normalized gains after this sample. The time from
// acceptance to result is set by a 65-step serial divide for the derivative
// term and three 36-step serial divides for gain normalization, plus the
// multiply, accumulate and update steps on the shared 33x33 multiplier; the
// three normalization divides are skipped when the raw gain sum is zero. A
// stalled output register adds its stall. A new word is taken once the
// previous result is in the output register. Configuration writes are taken
// every cycle.
module neuron_adaptive_pid_core import nap_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  nap_in_if.sink     in_chan,
  nap_out_if.source  out_chan,
  nap_cfg_if.sink    cfg_chan
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_chan.ready = 1'b1;

  nap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nap_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .setpoint       (in_chan.setpoint),
    .measured       (in_chan.measured),
    .cfg_we         (cfg_chan.valid),
    .cfg_index      (cfg_chan.index),
    .cfg_data       (cfg_chan.data),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_drive      (out_chan.drive),
    .out_gain_prop  (out_chan.gain_prop),
    .out_gain_integ (out_chan.gain_integ),
    .out_gain_deriv (out_chan.gain_deriv)
  );

endmodule

FILE: sv/nap_checker.sv
// Port checker for the core and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_drive,
  input logic [19:0] out_gp,
  input logic [19:0] out_gi,
  input logic [19:0] out_gd
);

  `NAP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `NAP_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_drive) && $stable(out_gp))
  `NAP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `NAP_ASSERT_IMP(a_gain_bound, clk, rst_n, out_valid, out_gp <= 20'd65536 && out_gi <= 20'd65536 && out_gd <= 20'd65536)

endmodule

bind neuron_adaptive_pid_core nap_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_drive (out_chan.drive),
  .out_gp    (out_chan.gain_prop),
  .out_gi    (out_chan.gain_integ),
  .out_gd    (out_chan.gain_deriv)
);
